// ===== rtl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and codes for the pixel projection density unit.
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam logic [1:0] KIND_HIT     = 2'd0;
    localparam logic [1:0] KIND_ROW_END = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    localparam logic RESULT_ROW = 1'b0;
    localparam logic RESULT_BIN = 1'b1;

    localparam logic CFG_CENTROID_X       = 1'b0;
    localparam logic CFG_ROWS_PER_SECTION = 1'b1;

    localparam int COL_W   = 12;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [1:0]       kind;
        logic             in_range;
        logic             is_left;
        logic [COL_W-1:0] column;
    } ppd_entry_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } ppd_q_status_t;

endpackage

// ===== rtl/ppd_front.sv =====
// ----------------------------------------------------------------------------
// ppd_front
// Input acceptance and classification of items ahead of the queue.
// ----------------------------------------------------------------------------
module ppd_front #(
    parameter int COLUMNS = 256
) (
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,     // column [11:0], zero [15:12]
    input  logic [1:0]               s_tuser,     // kind [1:0]
    input  logic [ppd_pkg::COL_W-1:0] centroid_x,
    input  ppd_pkg::ppd_q_status_t   q_status,
    input  logic                     clr_busy,
    output logic                     push,
    output ppd_pkg::ppd_entry_t      entry
);
    import ppd_pkg::*;

    logic [COL_W-1:0] column;

    always_comb begin
        column         = s_tdata[COL_W-1:0];
        s_tready       = !q_status.full && !clr_busy;
        entry.kind     = s_tuser;
        entry.column   = column;
        entry.in_range = (32'(column) < COLUMNS);
        entry.is_left  = (column < centroid_x);
        push           = s_tvalid && s_tready &&
                         (s_tuser == KIND_HIT || s_tuser == KIND_ROW_END ||
                          s_tuser == KIND_READ);
    end

endmodule

// ===== rtl/ppd_queue.sv =====
// ----------------------------------------------------------------------------
// ppd_queue
// Short FIFO that decouples classification from the counting pipeline.
// ----------------------------------------------------------------------------
module ppd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ppd_pkg::ppd_entry_t    push_entry,
    input  logic                   pop,
    output ppd_pkg::ppd_entry_t    head,
    output ppd_pkg::ppd_q_status_t status
);
    import ppd_pkg::*;

    ppd_entry_t         q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
        head         = q_mem_reg[rd_ptr_reg];
        status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
        status.empty = (count_reg == '0);
        status.count = count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/ppd_back.sv =====
// ----------------------------------------------------------------------------
// ppd_back
// Bin memory, section counters and result register.
// ----------------------------------------------------------------------------
module ppd_back #(
    parameter int COLUMNS   = 256,
    parameter int BIN_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         rows_per_section,
    input  ppd_pkg::ppd_entry_t head,
    input  logic                q_empty,
    output logic                pop,
    output logic                clr_busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [127:0]        m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import ppd_pkg::*;

    localparam int CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    logic [BIN_WIDTH-1:0] bins_mem [COLUMNS];
    logic [BIN_WIDTH-1:0] rd_data_reg;

    logic                 s1_valid_reg;
    ppd_entry_t           s1_entry_reg;
    logic                 fwd_valid_reg;
    logic [CIDX_W-1:0]    fwd_idx_reg;
    logic [BIN_WIDTH-1:0] fwd_val_reg;

    logic                 clr_busy_reg;
    logic [CIDX_W-1:0]    clr_idx_reg;

    logic [31:0] left_reg, left_next;
    logic [31:0] right_reg, right_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] prev_reg, prev_next;
    logic [15:0] rows_reg, rows_next;
    logic [15:0] items_reg, items_next;

    logic         out_valid_reg, out_valid_next;
    logic [127:0] out_data_reg, out_data_next;
    logic [1:0]   out_user_reg, out_user_next;

    logic                 advance;
    logic [CIDX_W-1:0]    s1_idx;
    logic [BIN_WIDTH-1:0] cur_bin;
    logic [31:0]          cur_bin32;
    logic [15:0]          bin_density;
    logic                 bin_we;
    logic [BIN_WIDTH-1:0] bin_wd;
    logic                 mem_we;
    logic [CIDX_W-1:0]    mem_wa;
    logic [BIN_WIDTH-1:0] mem_wd;
    logic [31:0]          diff;
    logic [15:0]          row_density;
    logic [15:0]          rows_inc;
    logic [15:0]          items_inc;
    logic [15:0]          limit;
    logic                 done;

    always_comb begin
        advance   = !out_valid_reg || m_tready;
        pop       = advance && !q_empty && !clr_busy_reg;
        clr_busy  = clr_busy_reg;
        s1_idx    = s1_entry_reg.column[CIDX_W-1:0];
        cur_bin   = (fwd_valid_reg && fwd_idx_reg == s1_idx) ? fwd_val_reg : rd_data_reg;
        cur_bin32 = 32'(cur_bin);
        bin_density = (cur_bin32 > 32'h0000_FFFF) ? 16'hFFFF : cur_bin32[15:0];

        bin_we = s1_valid_reg && s1_entry_reg.in_range &&
                 (s1_entry_reg.kind == KIND_HIT || s1_entry_reg.kind == KIND_READ);
        bin_wd = '0;
        if (s1_entry_reg.kind == KIND_HIT) begin
            bin_wd = (cur_bin == {BIN_WIDTH{1'b1}}) ? cur_bin : cur_bin + 1'b1;
        end

        if (clr_busy_reg) begin
            mem_we = 1'b1;
            mem_wa = clr_idx_reg;
            mem_wd = '0;
        end else begin
            mem_we = advance && bin_we;
            mem_wa = s1_idx;
            mem_wd = bin_wd;
        end

        diff        = (total_reg >= prev_reg) ? total_reg - prev_reg : 32'd0;
        row_density = (diff > 32'h0000_FFFF) ? 16'hFFFF : diff[15:0];
        rows_inc    = (rows_reg == 16'hFFFF) ? rows_reg : rows_reg + 16'd1;
        items_inc   = (items_reg == 16'hFFFF) ? items_reg : items_reg + 16'd1;
        limit       = (rows_per_section == 16'd0) ? 16'd1 : rows_per_section;
        done        = (rows_inc >= limit);

        left_next      = left_reg;
        right_next     = right_reg;
        total_next     = total_reg;
        prev_next      = prev_reg;
        rows_next      = rows_reg;
        items_next     = items_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (advance && s1_valid_reg) begin
            case (s1_entry_reg.kind)
                KIND_HIT: begin
                    items_next = items_inc;
                    if (s1_entry_reg.in_range) begin
                        if (s1_entry_reg.is_left) begin
                            left_next = (left_reg == 32'hFFFF_FFFF) ? left_reg
                                                                    : left_reg + 32'd1;
                        end else begin
                            right_next = (right_reg == 32'hFFFF_FFFF) ? right_reg
                                                                      : right_reg + 32'd1;
                        end
                        total_next = (total_reg == 32'hFFFF_FFFF) ? total_reg
                                                                  : total_reg + 32'd1;
                    end
                end
                KIND_ROW_END: begin
                    out_valid_next = 1'b1;
                    out_user_next  = {done, RESULT_ROW};
                    out_data_next  = {16'd0, items_inc, right_reg, left_reg,
                                      rows_reg, row_density};
                    if (done) begin
                        left_next  = '0;
                        right_next = '0;
                        total_next = '0;
                        prev_next  = '0;
                        rows_next  = '0;
                        items_next = '0;
                    end else begin
                        prev_next  = total_reg;
                        rows_next  = rows_inc;
                        items_next = items_inc;
                    end
                end
                KIND_READ: begin
                    out_valid_next = 1'b1;
                    out_user_next  = {1'b0, RESULT_BIN};
                    out_data_next  = {(s1_entry_reg.in_range ? bin_density : 16'd0), 112'd0};
                end
                default: begin
                end
            endcase
        end

        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
        m_tuser  = out_user_reg[0];
        m_tlast  = out_user_reg[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            total_reg     <= '0;
            prev_reg      <= '0;
            rows_reg      <= '0;
            items_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == CIDX_W'(COLUMNS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (advance) begin
                s1_valid_reg  <= pop;
                fwd_valid_reg <= bin_we;
            end
            left_reg      <= left_next;
            right_reg     <= right_next;
            total_reg     <= total_next;
            prev_reg      <= prev_next;
            rows_reg      <= rows_next;
            items_reg     <= items_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_entry_reg <= head;
        end
        if (advance) begin
            fwd_idx_reg <= s1_idx;
            fwd_val_reg <= bin_wd;
        end
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bins_mem[mem_wa] <= mem_wd;
        end
        if (pop) begin
            rd_data_reg <= bins_mem[head.column[CIDX_W-1:0]];
        end
    end

endmodule

// ===== rtl/pixel_projection_densities_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_projection_densities_unit
// Row and column projection counter for a thresholded pixel stream.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the output does not stall: pixel
// hits, row ends and bin reads. Each item passes through the counting stage,
// where the bin read-modify-write uses a registered memory read with
// forwarding of the previous write, so back-to-back hits on the same column
// run at full rate. A row end or a bin read yields one result; hits yield
// none. After reset the bin memory is cleared one bin per cycle, and while
// it is cleared s_tready is low. Configuration writes are taken at any time
// but are meant for idle periods.
module pixel_projection_densities_unit #(
    parameter int COLUMNS   = 256,
    parameter int BIN_WIDTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // column [11:0], zero [15:12]
    input  logic [1:0]   s_tuser,   // kind [1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_density [15:0], row_index [31:16], left_total [63:32],
    // right_total [95:64], items_seen [111:96], column_density [127:112]
    output logic [127:0] m_tdata,
    output logic         m_tuser,   // result_kind [0]
    output logic         m_tlast    // section_done
);
    import ppd_pkg::*;

    logic [COL_W-1:0] centroid_reg;
    logic [15:0]      rows_per_section_reg;

    logic          push;
    logic          pop;
    logic          clr_busy;
    ppd_entry_t    push_entry;
    ppd_entry_t    head;
    ppd_q_status_t q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centroid_reg         <= '0;
            rows_per_section_reg <= 16'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CENTROID_X:       centroid_reg         <= cfg_wdata[COL_W-1:0];
                CFG_ROWS_PER_SECTION: rows_per_section_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ppd_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .centroid_x (centroid_reg),
        .q_status   (q_status),
        .clr_busy   (clr_busy),
        .push       (push),
        .entry      (push_entry)
    );

    ppd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    ppd_back #(
        .COLUMNS   (COLUMNS),
        .BIN_WIDTH (BIN_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .rows_per_section (rows_per_section_reg),
        .head             (head),
        .q_empty          (q_status.empty),
        .pop              (pop),
        .clr_busy         (clr_busy),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast)
    );

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("Input accepted during the bin clearing pass.");

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> clr_busy)
        else $error("Bin clearing pass did not start after reset.");

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (q_status.count < Q_CNT_W'(Q_DEPTH)))
        else $error("Queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("Queue read while empty.");

    a_read_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == RESULT_BIN) |-> (m_tdata[111:0] == '0 && !m_tlast))
        else $error("Bin read result carries row fields.");

endmodule

// ===== verif/ppd_projection_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppd_projection_checker
// Watches the input, result and register ports of the projection unit, keeps
// its own copy of the counters and density bins, and compares every result
// transfer field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module ppd_projection_checker #(
    parameter int COLUMNS   = 256,
    parameter int BIN_WIDTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,   // column [11:0], zero [15:12]
    input  logic [1:0]   s_tuser,   // kind [1:0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    // row_density [15:0], row_index [31:16], left_total [63:32],
    // right_total [95:64], items_seen [111:96], column_density [127:112]
    input  logic [127:0] m_tdata,
    input  logic         m_tuser,   // result_kind [0]
    input  logic         m_tlast,   // section_done
    output int           fail_count,
    output int           pending,
    output int           checked
);
    import ppd_pkg::*;

    localparam longint unsigned BIN_MAX = (64'd1 << BIN_WIDTH) - 1;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] row_density;
        logic [15:0] row_index;
        logic        section_done;
        logic [31:0] left_total;
        logic [31:0] right_total;
        logic [15:0] items_seen;
        logic [15:0] column_density;
    } proj_result_t;

    proj_result_t expected_results[$];
    proj_result_t want;
    proj_result_t got;

    logic [11:0] centroid;
    logic [15:0] section_rows;

    logic [31:0] left_hits;
    logic [31:0] right_hits;
    logic [31:0] last_total;
    logic [15:0] rows_in_section;
    logic [15:0] section_items;
    longint unsigned density_bins[COLUMNS];

    task automatic project_item(input logic [1:0] kind, input logic [11:0] col);
        proj_result_t r;
        logic [32:0] sum;
        logic [31:0] total;
        logic [31:0] diff;
        logic [16:0] limit;
        longint unsigned v;
        r = '0;
        v = 0;
        case (kind)
            KIND_HIT: begin
                if (section_items != 16'hFFFF) section_items = section_items + 1'b1;
                if (col < COLUMNS) begin
                    if (col < centroid) begin
                        if (left_hits != 32'hFFFF_FFFF) left_hits = left_hits + 1'b1;
                    end else begin
                        if (right_hits != 32'hFFFF_FFFF) right_hits = right_hits + 1'b1;
                    end
                    if (density_bins[col] < BIN_MAX) density_bins[col] += 1;
                end
            end
            KIND_ROW_END: begin
                sum = {1'b0, left_hits} + {1'b0, right_hits};
                total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                diff = (total >= last_total) ? total - last_total : 32'd0;
                limit = (section_rows == 16'd0) ? 17'd1 : {1'b0, section_rows};
                if (section_items != 16'hFFFF) section_items = section_items + 1'b1;
                r.result_kind = RESULT_ROW;
                r.row_density = (diff > 32'hFFFF) ? 16'hFFFF : diff[15:0];
                r.row_index = rows_in_section;
                if (rows_in_section != 16'hFFFF) rows_in_section = rows_in_section + 1'b1;
                last_total = total;
                r.section_done = ({1'b0, rows_in_section} >= limit);
                r.left_total = left_hits;
                r.right_total = right_hits;
                r.items_seen = section_items;
                if (r.section_done) begin
                    left_hits = '0;
                    right_hits = '0;
                    last_total = '0;
                    rows_in_section = '0;
                    section_items = '0;
                end
                expected_results.push_back(r);
            end
            KIND_READ: begin
                if (col < COLUMNS) begin
                    v = density_bins[col];
                    density_bins[col] = 0;
                end
                r.result_kind = RESULT_BIN;
                r.column_density = (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
                expected_results.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val != act_val) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            centroid <= '0;
            section_rows <= 16'd1;
            left_hits = '0;
            right_hits = '0;
            last_total = '0;
            rows_in_section = '0;
            section_items = '0;
            foreach (density_bins[i]) density_bins[i] = 0;
            expected_results.delete();
            fail_count = 0;
            checked <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast,
                       m_tdata[63:32], m_tdata[95:64], m_tdata[111:96],
                       m_tdata[127:112]};
                checked <= checked + 1;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.result_kind, got.result_kind);
                    check_field("row_density", want.row_density, got.row_density);
                    check_field("row_index", want.row_index, got.row_index);
                    check_field("section_done", want.section_done, got.section_done);
                    check_field("left_total", want.left_total, got.left_total);
                    check_field("right_total", want.right_total, got.right_total);
                    check_field("items_seen", want.items_seen, got.items_seen);
                    check_field("column_density", want.column_density,
                                got.column_density);
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_CENTROID_X) begin
                    centroid <= cfg_wdata[11:0];
                end else begin
                    section_rows <= cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) project_item(s_tuser, s_tdata[11:0]);
        end
        pending <= expected_results.size();
    end

endmodule

// ===== verif/tb_pixel_projection_densities_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_projection_densities_unit
// Drives hits, row ends and bin reads into the projection unit under bursty
// input traffic and a stalling output, across several register settings.
// A directed part covers field extremes, out-of-range columns, the unused
// kind, a zero row count, a row count lowered mid-section and a long run of
// hits on one column; a random part sends rows of hits with reads mixed in.
// The checker module compares every result with its own prediction.
// ----------------------------------------------------------------------------
module tb_pixel_projection_densities_unit;
    import ppd_pkg::*;

    localparam int COLUMNS = 256;
    localparam int BIN_WIDTH = 16;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT = 8000;
    localparam int HOLD_OFF_CYCLES = 1200;
    localparam int HOLD_OFF_AFTER = 150;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic         cfg_index;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    int fail_count;
    int pending;
    int checked;

    int idle_cycles = 0;
    int burst_left = 0;
    bit steady = 0;
    int hits_sent = 0;
    int row_ends_sent = 0;
    int reads_sent = 0;
    int noise_sent = 0;
    int settings_used = 0;

    pixel_projection_densities_unit #(
        .COLUMNS(COLUMNS),
        .BIN_WIDTH(BIN_WIDTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    ppd_projection_checker #(
        .COLUMNS(COLUMNS),
        .BIN_WIDTH(BIN_WIDTH)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .fail_count(fail_count),
        .pending(pending),
        .checked(checked)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: stall modes are drawn at random and changed in turn, and once the
    // output is held off long enough for the unit to back up into its input.
    initial begin
        int mode;
        int mode_left;
        int phase;
        bit held;
        mode = 0;
        mode_left = 0;
        phase = 0;
        held = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && checked >= HOLD_OFF_AFTER) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(30, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (phase % 5) > 1;
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [11:0] col);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, col};
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        case (kind)
            KIND_HIT: hits_sent++;
            KIND_ROW_END: row_ends_sent++;
            KIND_READ: reads_sent++;
            default: noise_sent++;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic index, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_registers(input logic [11:0] centroid, input logic [15:0] rows);
        wait_idle();
        write_reg(CFG_CENTROID_X, {4'd0, centroid});
        write_reg(CFG_ROWS_PER_SECTION, rows);
        settings_used++;
    endtask

    task automatic random_column(output logic [11:0] col, input logic [11:0] centroid);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            col = 12'($urandom_range(0, COLUMNS - 1));
        end else if (pick < 17 && centroid < COLUMNS) begin
            col = (centroid == 0) ? 12'd0 : centroid - 12'($urandom_range(0, 1));
        end else begin
            col = 12'($urandom_range(0, 4095));
        end
    endtask

    initial begin
        logic [11:0] centroid;
        logic [15:0] rows;
        logic [11:0] col;
        int sent;
        int hits;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CENTROID_X;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_HIT;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_registers(12'd128, 16'd3);
        send_item(KIND_HIT, 12'd0);
        send_item(KIND_HIT, 12'd127);
        send_item(KIND_HIT, 12'd128);
        send_item(KIND_HIT, 12'd255);
        send_item(KIND_HIT, 12'd256);
        send_item(KIND_HIT, 12'd4095);
        send_item(KIND_HIT, 12'hAAA);
        send_item(KIND_HIT, 12'h555);
        send_item(KIND_UNUSED, 12'd4095);
        send_item(KIND_HIT, 12'd255);
        send_item(KIND_ROW_END, 12'd0);
        send_item(KIND_HIT, 12'd42);
        send_item(KIND_ROW_END, 12'd4095);
        send_item(KIND_READ, 12'd255);
        send_item(KIND_READ, 12'd255);
        send_item(KIND_READ, 12'd4095);
        send_item(KIND_READ, 12'h800);
        send_item(KIND_ROW_END, 12'd0);
        send_item(KIND_READ, 12'd0);
        send_item(KIND_READ, 12'd128);
        send_item(KIND_HIT, 12'h0AA);
        send_item(KIND_HIT, 12'h055);
        send_item(KIND_ROW_END, 12'd0);

        // A zero row count behaves as one row per section.
        set_registers(12'd0, 16'd0);
        send_item(KIND_HIT, 12'd3);
        send_item(KIND_HIT, 12'd200);
        send_item(KIND_ROW_END, 12'd0);
        send_item(KIND_ROW_END, 12'd0);
        send_item(KIND_READ, 12'd3);

        // Lower the row count after the section has already passed it.
        set_registers(12'd4095, 16'd10);
        repeat (5) begin
            send_item(KIND_HIT, 12'($urandom_range(0, COLUMNS - 1)));
            send_item(KIND_ROW_END, 12'd0);
        end
        set_registers(12'd4095, 16'd3);
        send_item(KIND_HIT, 12'd9);
        send_item(KIND_ROW_END, 12'd0);
        send_item(KIND_ROW_END, 12'd0);

        // Drive one column with a long unbroken run of hits within a single row.
        set_registers(12'd4095, 16'd65535);
        steady = 1;
        repeat (40) send_item(KIND_HIT, 12'd7);
        steady = 0;
        send_item(KIND_ROW_END, 12'd0);
        send_item(KIND_READ, 12'd7);
        set_registers(12'd4095, 16'd1);
        send_item(KIND_ROW_END, 12'd0);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: centroid = 12'd0;
                1: centroid = 12'd4095;
                default: centroid = 12'($urandom_range(0, COLUMNS - 1));
            endcase
            case ($urandom_range(0, 9))
                0: rows = 16'd0;
                1: rows = 16'd65535;
                default: rows = 16'($urandom_range(1, 8));
            endcase
            set_registers(centroid, rows);
            sent = 0;
            while (sent < 130) begin
                hits = $urandom_range(0, 10);
                repeat (hits) begin
                    random_column(col, centroid);
                    send_item(KIND_HIT, col);
                    sent++;
                    if ($urandom_range(0, 24) == 0) send_item(KIND_UNUSED,
                                                              12'($urandom_range(0, 4095)));
                end
                if ($urandom_range(0, 9) < 8) begin
                    send_item(KIND_ROW_END, 12'($urandom_range(0, 4095)));
                end else begin
                    random_column(col, centroid);
                    send_item(KIND_READ, col);
                end
                sent++;
                if ($urandom_range(0, 3) == 0) begin
                    random_column(col, centroid);
                    send_item(KIND_READ, col);
                    sent++;
                end
            end
        end

        wait_idle();
        $display("Sent %0d hits, %0d row ends, %0d bin reads, %0d unused-kind items",
                 hits_sent, row_ends_sent, reads_sent, noise_sent);
        $display("over %0d register settings; %0d results compared.",
                 settings_used, checked);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
